FILE: rtl/core/sdl_pkg.sv
// ----------------------------------------------------------------------------
// sdl_pkg
// Shared types, character codes, token kinds and the arrow and keyword
// tables of the sequence diagram lexer.
// ----------------------------------------------------------------------------
package sdl_pkg;

  localparam int LOOKAHEAD_DEPTH_DEF = 6;
  localparam int KEYWORD_MAX_LEN_DEF = 16;
  localparam int OFFSET_BITS_DEF     = 20;

  // decisions need this many characters in the window
  localparam int WINDOW_NEED = 6;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = 2;
  localparam int TQ_DEPTH = 8;
  localparam int TQ_PTR_W = 3;

  localparam logic [19:0] FIELD_MAX = 20'hFFFFF;

  localparam logic [5:0] KIND_EOF     = 6'd0;
  localparam logic [5:0] KIND_NEWLINE = 6'd1;
  localparam logic [5:0] KIND_SEMI    = 6'd2;
  localparam logic [5:0] KIND_ARROW   = 6'd3;
  localparam logic [5:0] KIND_CENTRAL = 6'd4;
  localparam logic [5:0] KIND_PLUS    = 6'd5;
  localparam logic [5:0] KIND_MINUS   = 6'd6;
  localparam logic [5:0] KIND_COLON   = 6'd7;
  localparam logic [5:0] KIND_COMMA   = 6'd8;
  localparam logic [5:0] KIND_INVALID = 6'd9;
  localparam logic [5:0] KIND_WORD    = 6'd10;
  localparam logic [5:0] KIND_KW_BASE = 6'd11;

  localparam logic [15:0] CH_LF     = 16'h000A;
  localparam logic [15:0] CH_CR     = 16'h000D;
  localparam logic [15:0] CH_SEMI   = 16'h003B;
  localparam logic [15:0] CH_HASH   = 16'h0023;
  localparam logic [15:0] CH_PCT    = 16'h0025;
  localparam logic [15:0] CH_LBRACE = 16'h007B;
  localparam logic [15:0] CH_LPAR   = 16'h0028;
  localparam logic [15:0] CH_RPAR   = 16'h0029;
  localparam logic [15:0] CH_PLUS   = 16'h002B;
  localparam logic [15:0] CH_MINUS  = 16'h002D;
  localparam logic [15:0] CH_COLON  = 16'h003A;
  localparam logic [15:0] CH_COMMA  = 16'h002C;
  localparam logic [15:0] CH_EQ     = 16'h003D;

  typedef struct packed {
    logic [15:0] char_code;
    logic        char_valid;
    logic        end_of_source;
  } item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [19:0] token_start;
    logic [19:0] token_length;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        last_token;
  } token_t;

  // classified character
  typedef struct packed {
    logic [15:0] code;
    logic        space;
    logic [7:0]  fold;
  } ch_t;

  typedef struct packed {
    ch_t  ch;
    logic valid;
    logic eos;
  } fq_entry_t;

  typedef struct packed {
    logic      avail;
    fq_entry_t entry;
  } fq_out_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } emit_t;

  typedef logic [WINDOW_NEED-1:0][15:0] win_t;

  localparam int KW_TEXT_LEN = 15;
  typedef logic [KW_TEXT_LEN-1:0][7:0] kw_text_t;

  localparam int ARROW_NUM = 26;

  // right-justified text, first character in the highest used byte
  localparam logic [47:0] ARROW_PAT [ARROW_NUM] = '{
    "<<-->>", "<<->>", "--|\\", "--|/", "/|--", "\\|--", "//--", "\\\\--",
    "--\\\\", "--//", "-|\\", "-|/", "/|-", "\\|-", "//-", "\\\\-",
    "-\\\\", "-//", "-->>", "->>", "--x", "--)", "-->", "-x", "-)", "->"};

  localparam logic [2:0] ARROW_LEN [ARROW_NUM] = '{
    3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2};

  localparam int KW_NUM = 35;

  localparam logic [119:0] KW_TEXT [KW_NUM] = '{
    "sequencediagram", "participant", "actor", "create", "destroy", "as",
    "box", "end", "autonumber", "off", "activate", "deactivate", "note",
    "left", "right", "of", "over", "loop", "rect", "opt", "alt", "else",
    "par", {"par", "_over"}, "and", "critical", "option", "break", "title",
    "acctitle", "accdescr", "links", "link", "properties", "details"};

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd15, 4'd11, 4'd5, 4'd6, 4'd7, 4'd2, 4'd3, 4'd3, 4'd10, 4'd3,
    4'd8, 4'd10, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd4, 4'd4, 4'd3,
    4'd3, 4'd4, 4'd3, 4'd8, 4'd3, 4'd8, 4'd6, 4'd5, 4'd5, 4'd8,
    4'd8, 4'd5, 4'd4, 4'd10, 4'd7};

  function automatic logic is_space(logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
           c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
           c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000;
  endfunction

  // length of the first arrow that matches at the window head, 0 for none
  function automatic logic [2:0] arrow_len(win_t w, logic [3:0] cnt);
    logic [2:0] r;
    logic       hit;
    logic [7:0] b;
    r = '0;
    for (int p = ARROW_NUM - 1; p >= 0; p--) begin
      hit = 1'b1;
      for (int i = 0; i < WINDOW_NEED; i++) begin
        if (i < int'(ARROW_LEN[p])) begin
          b = ARROW_PAT[p][8*(int'(ARROW_LEN[p]) - 1 - i) +: 8];
          if (i >= int'(cnt) || w[i] != {8'h00, b}) hit = 1'b0;
        end
      end
      if (hit) r = ARROW_LEN[p];
    end
    return r;
  endfunction

  function automatic logic [5:0] kw_kind(kw_text_t t, logic [19:0] size);
    logic [5:0] r;
    logic       hit;
    r = KIND_WORD;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      hit = (size == 20'(KW_LEN[k]));
      for (int i = 0; i < KW_TEXT_LEN; i++) begin
        if (i < int'(KW_LEN[k])) begin
          if (t[i] != KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]) hit = 1'b0;
        end
      end
      if (hit) r = KIND_KW_BASE + 6'(k);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sequence_diagram_lexer.sv
// ----------------------------------------------------------------------------
// sequence_diagram_lexer
// Streaming lexer for sequence diagram text: characters in, tokens out.
// ----------------------------------------------------------------------------
// One character item is taken per cycle while the input queue has room;
// the scanner resolves one window decision per cycle and writes up to two
// tokens into an eight-entry token queue, stalling while fewer than two
// entries are free. An end-of-source item drains the characters still in
// the lookahead window (at most five), then closes any open word and writes
// the end-of-file token; all state then returns to reset and a new run starts
// at offset 0. A four-entry input queue decouples intake from the scanner.
module sequence_diagram_lexer #(
  parameter int LOOKAHEAD_DEPTH = sdl_pkg::LOOKAHEAD_DEPTH_DEF,
  parameter int KEYWORD_MAX_LEN = sdl_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int OFFSET_BITS     = sdl_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  sdl_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output sdl_pkg::token_t  token
);
  import sdl_pkg::*;

  fq_out_t fq;
  logic    fq_pop;
  logic    room;
  emit_t   em;

  sdl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .fq     (fq),
    .fq_pop (fq_pop)
  );

  sdl_back #(
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .fq     (fq),
    .fq_pop (fq_pop),
    .room   (room),
    .emit   (em)
  );

  sdl_tokq u_tokq (
    .clk   (clk),
    .rst   (rst),
    .em    (em),
    .room  (room),
    .empty (empty),
    .pop   (pop),
    .token (token)
  );

endmodule

FILE: rtl/core/sdl_front.sv
// ----------------------------------------------------------------------------
// sdl_front
// Input side: accepts items, classifies the character and queues the result
// for the scanner.
// ----------------------------------------------------------------------------
module sdl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  sdl_pkg::item_t    item,
  output sdl_pkg::fq_out_t  fq,
  input  logic              fq_pop
);
  import sdl_pkg::*;

  localparam int CNT_W = $clog2(FQ_DEPTH + 1);

  fq_entry_t            mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]  rd_ptr;
  logic [FQ_PTR_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]     count;
  fq_entry_t            cls;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    cls.ch.code  = item.char_code;
    cls.ch.space = is_space(item.char_code);
    if (item.char_code >= 16'h0041 && item.char_code <= 16'h005A) begin
      cls.ch.fold = item.char_code[7:0] + 8'd32;
    end else if (item.char_code < 16'h0080) begin
      cls.ch.fold = item.char_code[7:0];
    end else begin
      cls.ch.fold = 8'h00;
    end
    cls.valid = item.char_valid;
    cls.eos   = item.end_of_source;
  end

  assign full     = (count == CNT_W'(FQ_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = fq_pop && (count != '0);
  assign fq.avail = (count != '0);
  assign fq.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/core/sdl_tokq.sv
// ----------------------------------------------------------------------------
// sdl_tokq
// Token queue: takes up to two tokens a cycle from the scanner and hands
// them out one at a time.
// ----------------------------------------------------------------------------
module sdl_tokq (
  input  logic             clk,
  input  logic             rst,
  input  sdl_pkg::emit_t   em,
  output logic             room,
  output logic             empty,
  input  logic             pop,
  output sdl_pkg::token_t  token
);
  import sdl_pkg::*;

  localparam int CNT_W = $clog2(TQ_DEPTH + 1);

  token_t               mem [TQ_DEPTH];
  logic [TQ_PTR_W-1:0]  rd_ptr;
  logic [TQ_PTR_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_pop;
  logic [1:0]           n_push;

  assign empty  = (count == '0);
  assign room   = (count <= CNT_W'(TQ_DEPTH - 2));
  assign token  = mem[rd_ptr];
  assign do_pop = pop && !empty;
  assign n_push = 2'(em.v0) + 2'(em.v1);

  always_ff @(posedge clk) begin
    if (em.v0) mem[wr_ptr] <= em.t0;
    if (em.v1) mem[wr_ptr + 1'b1] <= em.t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + TQ_PTR_W'(n_push);
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(n_push) - CNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/core/sdl_back.sv
// ----------------------------------------------------------------------------
// sdl_back
// Scanner: holds the lookahead window and word state, takes one window
// decision per cycle while the token queue has room, emits up to two tokens.
// ----------------------------------------------------------------------------
module sdl_back #(
  parameter int LOOKAHEAD_DEPTH = sdl_pkg::LOOKAHEAD_DEPTH_DEF,
  parameter int KEYWORD_MAX_LEN = sdl_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int OFFSET_BITS     = sdl_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sdl_pkg::fq_out_t  fq,
  output logic              fq_pop,
  input  logic              room,
  output sdl_pkg::emit_t    emit
);
  import sdl_pkg::*;

  localparam int CNT_W  = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam int PIDX_W = $clog2(KEYWORD_MAX_LEN);
  localparam int CAP_W  = (OFFSET_BITS > 20) ? OFFSET_BITS : 20;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_WORD    = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;

  localparam logic PH_RUN   = 1'b0;
  localparam logic PH_DRAIN = 1'b1;

  ch_t                    win [LOOKAHEAD_DEPTH];
  logic [7:0]             prefix [KEYWORD_MAX_LEN];
  logic [CNT_W-1:0]       cnt;
  logic [1:0]             mode;
  logic                   phase;
  logic [OFFSET_BITS-1:0] wstart_off;
  logic [15:0]            wstart_col;
  logic [19:0]            wsize;
  logic [OFFSET_BITS-1:0] cur_off;
  logic [15:0]            cur_line;
  logic [15:0]            cur_col;

  ch_t                    wc [LOOKAHEAD_DEPTH];
  ch_t                    win_next [LOOKAHEAD_DEPTH];
  logic [CNT_W-1:0]       cnt_eff;
  logic                   step_run;
  logic                   app;
  logic                   eos_in;
  logic                   do_dec;
  logic                   finish;
  win_t                   wcode;
  kw_text_t               kw_text;
  ch_t                    c;
  logic [15:0]            c1;
  logic                   has1;
  logic [2:0]             n_arrow;
  logic                   central;
  logic                   brk;
  logic                   word_emit;
  logic                   tok;
  logic [5:0]             tok_kind;
  logic [2:0]             tok_len;
  logic [2:0]             n_use;
  logic                   start_word;
  logic                   add;
  logic [1:0]             mode_next;
  logic                   lf_last;
  token_t                 word_tok;
  token_t                 take_tok;
  token_t                 eof_tok;

  function automatic logic [19:0] cap_off(logic [OFFSET_BITS-1:0] v);
    logic [CAP_W-1:0] e;
    e = CAP_W'(v);
    return (e > CAP_W'(FIELD_MAX)) ? FIELD_MAX : e[19:0];
  endfunction

  assign step_run = (phase == PH_RUN) && fq.avail && room;
  assign fq_pop   = step_run;
  assign app      = step_run && fq.entry.valid;
  assign eos_in   = step_run && fq.entry.eos;
  assign cnt_eff  = cnt + CNT_W'(app);
  assign do_dec   = (phase == PH_RUN) ? (app && cnt_eff >= CNT_W'(WINDOW_NEED))
                                      : (room && cnt != '0);
  assign finish   = (phase == PH_DRAIN) && room && (cnt == '0);

  always_comb begin
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      wc[i] = (app && i == int'(cnt)) ? fq.entry.ch : win[i];
    end
    for (int i = 0; i < WINDOW_NEED; i++) begin
      wcode[i] = wc[i].code;
    end
    for (int i = 0; i < KW_TEXT_LEN; i++) begin
      kw_text[i] = prefix[i];
    end
  end

  assign c       = wc[0];
  assign c1      = wc[1].code;
  assign has1    = (cnt_eff >= CNT_W'(2));
  assign n_arrow = arrow_len(wcode, 4'(cnt_eff));
  assign central = has1 && c.code == CH_LPAR && c1 == CH_RPAR;
  assign brk     = c.space || c.code == CH_SEMI || c.code == CH_COLON ||
                   c.code == CH_COMMA || c.code == CH_PLUS || c.code == CH_MINUS ||
                   c.code == CH_EQ || n_arrow != '0 || central;

  // window decision
  always_comb begin
    logic idle;
    idle       = 1'b0;
    word_emit  = 1'b0;
    tok        = 1'b0;
    tok_kind   = KIND_INVALID;
    tok_len    = 3'd1;
    n_use      = 3'd0;
    start_word = 1'b0;
    add        = 1'b0;
    mode_next  = mode;
    case (mode)
      MODE_WORD: begin
        if (brk) begin
          word_emit = 1'b1;
          idle      = 1'b1;
        end else begin
          add = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c.code == CH_LF || c.code == CH_CR) idle = 1'b1;
        else n_use = 3'd1;
      end
      default: idle = 1'b1;
    endcase
    if (idle) begin
      mode_next = MODE_IDLE;
      if (c.code == CH_CR) begin
        tok = 1'b1; tok_kind = KIND_NEWLINE;
        tok_len = (has1 && c1 == CH_LF) ? 3'd2 : 3'd1;
      end else if (c.code == CH_LF) begin
        tok = 1'b1; tok_kind = KIND_NEWLINE;
      end else if (c.code == CH_SEMI) begin
        tok = 1'b1; tok_kind = KIND_SEMI;
      end else if (c.space) begin
        n_use = 3'd1;
      end else if (c.code == CH_HASH || (c.code == CH_PCT && !(has1 && c1 == CH_LBRACE))) begin
        n_use     = 3'd1;
        mode_next = MODE_COMMENT;
      end else if (n_arrow != '0) begin
        tok = 1'b1; tok_kind = KIND_ARROW; tok_len = n_arrow;
      end else if (central) begin
        tok = 1'b1; tok_kind = KIND_CENTRAL; tok_len = 3'd2;
      end else if (c.code == CH_PLUS) begin
        tok = 1'b1; tok_kind = KIND_PLUS;
      end else if (c.code == CH_MINUS) begin
        tok = 1'b1; tok_kind = KIND_MINUS;
      end else if (c.code == CH_COLON) begin
        tok = 1'b1; tok_kind = KIND_COLON;
      end else if (c.code == CH_COMMA) begin
        tok = 1'b1; tok_kind = KIND_COMMA;
      end else if (c.code == CH_EQ) begin
        tok = 1'b1; tok_kind = KIND_INVALID;
      end else begin
        start_word = 1'b1;
        add        = 1'b1;
        mode_next  = MODE_WORD;
      end
    end
    if (tok) n_use = tok_len;
    if (add) n_use = 3'd1;
  end

  always_comb begin
    word_tok.token_kind   = kw_kind(kw_text, wsize);
    word_tok.token_start  = cap_off(wstart_off);
    word_tok.token_length = wsize;
    word_tok.token_line   = cur_line;
    word_tok.token_column = wstart_col;
    word_tok.last_token   = 1'b0;

    take_tok.token_kind   = tok_kind;
    take_tok.token_start  = cap_off(cur_off);
    take_tok.token_length = 20'(tok_len);
    take_tok.token_line   = cur_line;
    take_tok.token_column = cur_col;
    take_tok.last_token   = 1'b0;

    eof_tok.token_kind    = KIND_EOF;
    eof_tok.token_start   = cap_off(cur_off);
    eof_tok.token_length  = '0;
    eof_tok.token_line    = cur_line;
    eof_tok.token_column  = cur_col;
    eof_tok.last_token    = 1'b1;

    emit.v0 = 1'b0;
    emit.v1 = 1'b0;
    emit.t0 = take_tok;
    emit.t1 = take_tok;
    if (do_dec) begin
      if (word_emit) begin
        emit.v0 = 1'b1;
        emit.v1 = tok;
        emit.t0 = word_tok;
      end else begin
        emit.v0 = tok;
      end
    end else if (finish) begin
      emit.v0 = 1'b1;
      if (mode == MODE_WORD) begin
        emit.v1 = 1'b1;
        emit.t0 = word_tok;
        emit.t1 = eof_tok;
      end else begin
        emit.t0 = eof_tok;
      end
    end
  end

  // shift out the consumed characters
  always_comb begin
    logic [2:0] n;
    n = do_dec ? n_use : 3'd0;
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      if (i + int'(n) < LOOKAHEAD_DEPTH) win_next[i] = wc[i + int'(n)];
      else win_next[i] = wc[i];
    end
    lf_last = 1'b0;
    for (int i = 0; i < WINDOW_NEED; i++) begin
      if (i + 1 == int'(n_use) && wcode[i] == CH_LF) lf_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
      win[i] <= win_next[i];
    end
    if (do_dec && add) begin
      if (start_word) begin
        prefix[0] <= c.fold;
      end else if (wsize < 20'(KEYWORD_MAX_LEN)) begin
        prefix[wsize[PIDX_W-1:0]] <= c.fold;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0]            col_sum;
    logic [OFFSET_BITS:0]   off_sum;
    if (rst || finish) begin
      cnt        <= '0;
      mode       <= MODE_IDLE;
      phase      <= PH_RUN;
      wstart_off <= '0;
      wstart_col <= '0;
      wsize      <= '0;
      cur_off    <= '0;
      cur_line   <= '0;
      cur_col    <= '0;
    end else begin
      col_sum = {1'b0, cur_col} + 17'(n_use);
      off_sum = {1'b0, cur_off} + (OFFSET_BITS + 1)'(n_use);
      if (eos_in) phase <= PH_DRAIN;
      if (do_dec) begin
        cnt  <= cnt_eff - CNT_W'(n_use);
        mode <= mode_next;
        if (start_word) begin
          wstart_off <= cur_off;
          wstart_col <= cur_col;
          wsize      <= 20'd1;
        end else if (add && wsize != FIELD_MAX) begin
          wsize <= wsize + 20'd1;
        end
        if (lf_last) begin
          if (cur_line != 16'hFFFF) cur_line <= cur_line + 16'd1;
          cur_col <= '0;
        end else begin
          cur_col <= col_sum[16] ? 16'hFFFF : col_sum[15:0];
        end
        cur_off <= off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
      end else begin
        cnt <= cnt_eff;
      end
    end
  end

  a_run_window_short: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RUN |-> cnt < CNT_W'(WINDOW_NEED))
    else $error("window holds a full decision's worth while running");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    emit.v1 |-> emit.v0)
    else $error("second token without first");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (emit.v0 || emit.v1) |-> room)
    else $error("token emitted without queue room");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    finish |=> (cnt == '0 && mode == MODE_IDLE && phase == PH_RUN && cur_off == '0))
    else $error("state not cleared after end of file");

endmodule
